[hw/rtl/csfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfp_pkg
// Types, character codes and per-byte helpers for the checked sentence parser.
// ----------------------------------------------------------------------------
package csfp_pkg;

    localparam int UNIT_COUNT   = 4;
    localparam int NUMBER_WIDTH = 32;
    localparam int MASK_W       = 4;
    localparam int UNIT_ID_W    = 2;
    localparam int OUT_NUM_W    = 32;

    // Register map, by word index
    localparam logic REG_UNIT_ENABLE = 1'b0;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_G     = 8'h47;

    // Token positions that matter
    localparam logic [3:0] TOK_TAG    = 4'd1;
    localparam logic [3:0] TOK_UNIT   = 4'd2;
    localparam logic [3:0] TOK_STATUS = 4'd3;
    localparam logic [3:0] TOK_RES    = 4'd7;
    localparam logic [3:0] TOK_MAX    = 4'd15;

    localparam logic [2:0] TAG_DONE     = 3'd3;
    localparam logic [2:0] TAG_MISMATCH = 3'd4;
    localparam logic [1:0] HEX_EXPECTED = 2'd2;
    localparam logic [1:0] HEX_SAT      = 2'd3;

    typedef enum logic [1:0] {
        ST_PUBLISHED = 2'd0,
        ST_CKSUM_BAD = 2'd1,
        ST_NOT_RECORD = 2'd2,
        ST_BAD_NUMBER = 2'd3
    } line_status_t;

    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } num_phase_t;

    typedef struct packed {
        logic                    neg;
        logic                    got_digit;
        num_phase_t              phase;
        logic [NUMBER_WIDTH-1:0] mag;
    } num_t;

    typedef struct packed {
        logic [7:0] running_sum;
        logic       has_bytes;
        logic       past_star;
        logic [1:0] hex_count;
        logic [7:0] received_sum;
        logic       hex_good;
        logic [3:0] token_count;
        logic       inside_token;
        logic [2:0] tag_pos;
        num_t [2:0] nums;
    } line_state_t;

    localparam logic [NUMBER_WIDTH-1:0] NUM_TOP = {1'b1, {(NUMBER_WIDTH-1){1'b0}}};

    localparam num_t NUM_CLEAR = '{
        neg: 1'b0, got_digit: 1'b0, phase: PH_LEAD, mag: '0
    };

    localparam line_state_t LINE_CLEAR = '{
        running_sum: 8'h00, has_bytes: 1'b0, past_star: 1'b0, hex_count: 2'd0,
        received_sum: 8'h00, hex_good: 1'b1, token_count: 4'd0,
        inside_token: 1'b0, tag_pos: 3'd0, nums: {3{NUM_CLEAR}}
    };

    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_B;
            3'd1:    ch = CH_G;
            default: ch = CH_F;
        endcase
        return ch;
    endfunction

    // Advance one number parser by one character (never a space).
    function automatic num_t num_feed(input num_t n, input logic [7:0] c);
        num_t                    r;
        logic                    dig;
        logic [NUMBER_WIDTH-1:0] lim;
        logic [NUMBER_WIDTH+3:0] wide;
        logic [NUMBER_WIDTH+3:0] prod;
        r    = n;
        dig  = (c >= CH_0) && (c <= CH_9);
        lim  = n.neg ? NUM_TOP : NUM_TOP - 1'b1;
        wide = {4'b0, n.mag};
        // mag*10 + digit as shifts; saturate where it passes the limit
        prod = (wide << 3) + (wide << 1) + {{NUMBER_WIDTH{1'b0}}, c[3:0]};
        if (n.phase == PH_LEAD && (c == CH_TAB || c == CH_VT || c == CH_FF)) begin
            r = n;
        end else if (n.phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
            r.neg   = (c == CH_MINUS);
            r.phase = PH_SIGN;
        end else if (n.phase == PH_DONE) begin
            r = n;
        end else if (!dig) begin
            r.phase = PH_DONE;
        end else begin
            r.phase     = PH_DIGITS;
            r.got_digit = 1'b1;
            r.mag       = (prod > {4'b0, lim}) ? lim : prod[NUMBER_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [OUT_NUM_W-1:0] num_value(input num_t n);
        logic [63:0] m;
        m = 64'(n.mag);
        if (n.neg) begin
            m = -m;
        end
        return m[OUT_NUM_W-1:0];
    endfunction

endpackage

[hw/rtl/checked_sentence_field_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_sentence_field_parser
// Parses checksummed ASCII sentences byte by byte and reports one status word
// per non-empty line, with the unit id, status and resistance fields.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                            Moves
//  -------   ------------------------------   ---------------------------------
//  s_        s_valid/s_ready, s_rx_byte       one received byte per word
//  m_        m_valid/m_ready, m_line_status,  one result word per LF that ends
//            m_unit_id, m_unit_status,        a non-empty line
//            m_resistance_kohm
//  APB       psel/penable/pwrite/paddr/...    unit_enable_mask at address 0
//
//  One byte per cycle sustained while no result blocks the input. A byte is
//  held in the input register while the line state updates; an LF that leaves
//  it loads the result register, whose word is then offered on m_valid.
//  Reset (aresetn low, synchronous) clears the line state, mask and valids.
//  When a result waits on m_ready, bytes keep flowing through the input
//  register; the input stalls only while an LF that ends a non-empty line
//  sits in the input register.
//
module checked_sentence_field_parser (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // byte input
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [7:0]                               s_rx_byte,
    // result output
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [1:0]                               m_line_status,
    output logic [csfp_pkg::UNIT_ID_W-1:0]           m_unit_id,
    output logic signed [csfp_pkg::OUT_NUM_W-1:0]    m_unit_status,
    output logic signed [csfp_pkg::OUT_NUM_W-1:0]    m_resistance_kohm,
    // configuration
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [2:0]                               paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import csfp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [MASK_W-1:0] mask_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (cfg_write && paddr[2] == REG_UNIT_ENABLE) begin
            mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_UNIT_ENABLE) begin
            prdata = {{(32-MASK_W){1'b0}}, mask_reg};
        end
    end

    // ------------------------------------------------------------------
    // Input register: decouples s_ready from a waiting result
    // ------------------------------------------------------------------
    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic        advance;
    logic        emit;
    logic        out_free;

    assign out_free = !m_valid || m_ready;
    // Hold the byte only when it would produce a result that has nowhere to go
    assign advance  = byte_valid_reg && (!emit || out_free);
    assign s_ready  = !byte_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (s_ready) begin
            byte_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Line state update for the byte in the input register
    // ------------------------------------------------------------------
    line_state_t  state_reg;
    line_state_t  state_next;
    logic         is_lf;
    logic         is_cr;
    logic         is_dig;
    logic         is_hex;
    logic [3:0]   nib;
    logic [3:0]   tok;
    logic         cks_ok;
    logic         rec_ok;
    logic         nums_ok;
    logic         unit_ok;
    line_status_t status_next;

    assign is_lf  = (byte_reg == CH_LF);
    assign is_cr  = (byte_reg == CH_CR);
    assign is_dig = (byte_reg >= CH_0) && (byte_reg <= CH_9);
    assign is_hex = is_dig || ((byte_reg >= CH_A) && (byte_reg <= CH_F));
    // '0'..'9' keep the low nibble; 'A'..'F' add nine to it
    assign nib    = is_dig ? byte_reg[3:0] : byte_reg[3:0] + 4'd9;

    always_comb begin
        state_next = state_reg;
        tok        = state_reg.token_count;
        emit       = 1'b0;
        if (is_lf) begin
            // close the line; an empty line gives no word
            emit       = state_reg.has_bytes;
            state_next = LINE_CLEAR;
        end else if (!is_cr) begin
            state_next.has_bytes = 1'b1;
            if (state_reg.past_star) begin
                if (state_reg.hex_count != HEX_SAT) begin
                    state_next.hex_count = state_reg.hex_count + 2'd1;
                end
                if (is_hex) begin
                    state_next.received_sum = {state_reg.received_sum[3:0], nib};
                end else begin
                    state_next.hex_good = 1'b0;
                end
            end else if (byte_reg == CH_STAR) begin
                state_next.past_star = 1'b1;
            end else begin
                state_next.running_sum = state_reg.running_sum + byte_reg;
                if (byte_reg == CH_SPACE) begin
                    state_next.inside_token = 1'b0;
                end else begin
                    if (!state_reg.inside_token && state_reg.token_count != TOK_MAX) begin
                        tok = state_reg.token_count + 4'd1;
                    end
                    state_next.inside_token = 1'b1;
                    state_next.token_count  = tok;
                    case (tok)
                        TOK_TAG: begin
                            if (state_reg.tag_pos < TAG_DONE &&
                                byte_reg == tag_char(state_reg.tag_pos)) begin
                                state_next.tag_pos = state_reg.tag_pos + 3'd1;
                            end else begin
                                state_next.tag_pos = TAG_MISMATCH;
                            end
                        end
                        TOK_UNIT:   state_next.nums[0] = num_feed(state_reg.nums[0], byte_reg);
                        TOK_STATUS: state_next.nums[1] = num_feed(state_reg.nums[1], byte_reg);
                        TOK_RES:    state_next.nums[2] = num_feed(state_reg.nums[2], byte_reg);
                        default:    state_next.nums = state_reg.nums;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LINE_CLEAR;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Line verdict, evaluated on the closing LF
    // ------------------------------------------------------------------
    assign cks_ok  = state_reg.past_star && state_reg.hex_count == HEX_EXPECTED &&
                     state_reg.hex_good && state_reg.received_sum == state_reg.running_sum;
    assign rec_ok  = state_reg.tag_pos == TAG_DONE && state_reg.token_count >= TOK_RES;
    assign nums_ok = state_reg.nums[0].got_digit && state_reg.nums[1].got_digit &&
                     state_reg.nums[2].got_digit;
    assign unit_ok = !(state_reg.nums[0].neg && state_reg.nums[0].mag != '0) &&
                     state_reg.nums[0].mag < NUMBER_WIDTH'(UNIT_COUNT) &&
                     state_reg.nums[0].mag < NUMBER_WIDTH'(MASK_W) &&
                     mask_reg[state_reg.nums[0].mag[UNIT_ID_W-1:0]];

    always_comb begin
        if (!cks_ok) begin
            status_next = ST_CKSUM_BAD;
        end else if (!rec_ok) begin
            status_next = ST_NOT_RECORD;
        end else if (!nums_ok) begin
            status_next = ST_BAD_NUMBER;
        end else if (!unit_ok) begin
            status_next = ST_NOT_RECORD;
        end else begin
            status_next = ST_PUBLISHED;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance && emit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_line_status <= status_next;
            if (status_next == ST_PUBLISHED) begin
                m_unit_id         <= state_reg.nums[0].mag[UNIT_ID_W-1:0];
                m_unit_status     <= num_value(state_reg.nums[1]);
                m_resistance_kohm <= num_value(state_reg.nums[2]);
            end else begin
                m_unit_id         <= '0;
                m_unit_status     <= '0;
                m_resistance_kohm <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reject_zeroed : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_status != ST_PUBLISHED |->
            m_unit_id == '0 && m_unit_status == '0 && m_resistance_kohm == '0)
        else $error("rejected line carries nonzero fields");

    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> byte_valid_reg && m_valid && !m_ready && is_lf)
        else $error("input stalled without a blocked line end");

    a_result_from_lf : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(byte_valid_reg) && $past(byte_reg) == CH_LF)
        else $error("result produced without a line end");

    a_clear_after_lf : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_lf |=> !state_reg.has_bytes && state_reg.token_count == 4'd0 &&
            !state_reg.past_star)
        else $error("line state not cleared after line end");

    a_mask_write : assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write && paddr[2] == REG_UNIT_ENABLE |=> mask_reg == $past(pwdata[MASK_W-1:0]))
        else $error("enable mask write lost");

endmodule
